// File: rtl/mlbt_pkg.sv
// mlbt_pkg: shared types and codes for the learning bridge table
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package mlbt_pkg;

  // register indexes of the configuration port
  localparam logic REG_PORT_COUNT = 1'b0;
  localparam logic REG_MAX_AGE    = 1'b1;

  // item kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result actions
  localparam logic [1:0] ACT_FLOOD   = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_FILTER  = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  localparam logic [15:0] DEFAULT_MAX_AGE = 16'd300;
  localparam logic [6:0]  AGED_MAX        = 7'd127;

  // token that walks down the row of cells, one cell per cycle
  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [2:0]  ingress_port;
    logic [31:0] now;
    logic        hit;
    logic        free_found;
    logic        dst_found;
    logic [2:0]  dst_port;
    logic [6:0]  aged;
  } mlbt_tok_t;

  // broadcast write of a newly learned entry into the claimed cell
  typedef struct packed {
    logic        en;
    logic [47:0] mac;
    logic [2:0]  port;
    logic [31:0] now;
  } mlbt_inst_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] port_mask;
    logic       learned_new;
    logic       learn_dropped;
    logic [6:0] aged_count;
  } mlbt_res_t;

endpackage

// File: rtl/mlbt_if.sv
// mlbt_item_if and mlbt_result_if: valid/ready channels of the bridge table
// no dependencies
`timescale 1ns / 1ps

interface mlbt_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [47:0] src_mac;
  logic [47:0] dst_mac;
  logic [2:0]  ingress_port;

  modport source (output valid, kind, src_mac, dst_mac, ingress_port, input ready);
  modport sink   (input valid, kind, src_mac, dst_mac, ingress_port, output ready);
endinterface

interface mlbt_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] port_mask;
  logic       learned_new;
  logic       learn_dropped;
  logic [6:0] aged_count;

  modport source (output valid, action, port_mask, learned_new, learn_dropped, aged_count,
                  input ready);
  modport sink   (input valid, action, port_mask, learned_new, learn_dropped, aged_count,
                  output ready);
endinterface

// File: rtl/mac_learning_bridge_table_unit.sv
// mac_learning_bridge_table_unit: top level of the learning bridge table
// depends on mlbt_pkg, mlbt_if, mlbt_cell and mlbt_resolve
`timescale 1ns / 1ps

// usage
//  item channel: one transaction per frame (kind frame: learn source, look up
//    destination) or per one-second tick (kind tick: advance clock, age out)
//  result channel: exactly one transaction per item, in item order
//  cfg port: cfg_we with cfg_idx 0 writes port_count, cfg_idx 1 writes max_age;
//    write only while idle
//  the table is a row of TABLE_DEPTH cells, one entry each; an item walks the
//    row one cell per cycle, passing the head register, the cell row, the
//    finish register and the output register before its result transaction
//  one item is in the row at a time; the next item is taken once the previous
//    result has moved to the output register, so no new item is taken before
//    the previous result has left the finish register
//  a stalled receiver holds the output register; one more item may run
//    through the row and then waits in the finish register
//  reset clears every entry valid bit at once, sets now to zero, port_count
//    to NUM_PORTS and max_age to 300; no clearing pass is needed
module mac_learning_bridge_table_unit
  import mlbt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_PORTS   = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [15:0]   cfg_data,
  mlbt_item_if.sink     item,
  mlbt_result_if.source result
);

  // configuration and clock
  logic [3:0]  port_count;
  logic [15:0] max_age;
  logic [31:0] now_seconds;

  // control
  logic        busy;
  logic        accept;
  logic        done_valid;
  logic        out_valid;
  logic        move;
  mlbt_res_t   done;
  mlbt_res_t   out_res;

  // token chain: entry 0 is the head register, entry TABLE_DEPTH the tail
  mlbt_tok_t   tok_chain [TABLE_DEPTH+1];
  mlbt_res_t   tail_res;
  mlbt_inst_t  inst;

  assign item.ready = !busy;
  assign accept     = item.valid && !busy;
  // finished result goes out when the output register is free or emptying
  assign move       = done_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count  <= 4'(NUM_PORTS);
      max_age     <= DEFAULT_MAX_AGE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PORT_COUNT: port_count <= cfg_data[3:0];
        REG_MAX_AGE:    max_age    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // head of the chain: load the accepted item, tick advances the clock first
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds      <= 32'd0;
      tok_chain[0].vld <= 1'b0;
    end else begin
      tok_chain[0].vld <= accept;
      if (accept && (item.kind == KIND_TICK)) begin
        now_seconds <= now_seconds + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_chain[0].kind         <= item.kind;
      tok_chain[0].src_mac      <= item.src_mac;
      tok_chain[0].dst_mac      <= item.dst_mac;
      tok_chain[0].ingress_port <= item.ingress_port;
      tok_chain[0].now          <= (item.kind == KIND_TICK) ? now_seconds + 32'd1
                                                            : now_seconds;
      tok_chain[0].hit          <= 1'b0;
      tok_chain[0].free_found   <= 1'b0;
      tok_chain[0].dst_found    <= 1'b0;
      tok_chain[0].dst_port     <= 3'd0;
      tok_chain[0].aged         <= 7'd0;
    end
  end

  // row of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mlbt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .max_age (max_age),
      .tok_in  (tok_chain[i]),
      .inst    (inst),
      .tok_out (tok_chain[i+1])
    );
  end

  // result and learn install from the token leaving the row
  mlbt_resolve #(
    .NUM_PORTS (NUM_PORTS)
  ) u_resolve (
    .tok        (tok_chain[TABLE_DEPTH]),
    .port_count (port_count),
    .res        (tail_res),
    .inst       (inst)
  );

  // finish register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (tok_chain[TABLE_DEPTH].vld) begin
        done_valid <= 1'b1;
        done       <= tail_res;
      end
      if (move) begin
        out_valid  <= 1'b1;
        out_res    <= done;
        done_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (out_valid && result.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.action        = out_res.action;
  assign result.port_mask     = out_res.port_mask;
  assign result.learned_new   = out_res.learned_new;
  assign result.learn_dropped = out_res.learn_dropped;
  assign result.aged_count    = out_res.aged_count;

`ifndef SYNTH
  // no new transaction while a finished result still waits
  a_no_accept_when_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> !done_valid)
    else $error("item taken while result pending");

  // token leaving the row always lands in the finish register
  a_tail_to_done: assert property (@(posedge clk) disable iff (rst)
    tok_chain[TABLE_DEPTH].vld |=> done_valid)
    else $error("tail token lost");

  // install broadcast only when the head register holds no token and no item is taken
  a_install_alone: assert property (@(posedge clk) disable iff (rst)
    inst.en |-> !tok_chain[0].vld && !accept)
    else $error("install during chain traffic");

  // tick results carry no ports and no learn flags
  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    done_valid && (done.action == ACT_TICK) |->
      (done.port_mask == 8'd0) && !done.learned_new && !done.learn_dropped)
    else $error("tick result with frame fields");
`endif

endmodule

// File: rtl/mlbt_cell.sv
// mlbt_cell: one table entry plus one stage of the token chain
// depends on mlbt_pkg
`timescale 1ns / 1ps

module mlbt_cell
  import mlbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] max_age,
  input  mlbt_tok_t   tok_in,
  input  mlbt_inst_t  inst,
  output mlbt_tok_t   tok_out
);

  logic        valid;
  logic        claim;
  logic [47:0] mac;
  logic [2:0]  port;
  logic [31:0] last_seen;

  logic        is_frame;
  logic        is_tick;
  logic        src_m;
  logic        dst_m;
  logic [31:0] age;
  logic        old;
  mlbt_tok_t   tok_next;

  assign is_frame = tok_in.vld && (tok_in.kind == KIND_FRAME);
  assign is_tick  = tok_in.vld && (tok_in.kind == KIND_TICK);
  assign src_m    = valid && (mac == tok_in.src_mac);
  assign dst_m    = valid && (mac == tok_in.dst_mac);
  assign age      = tok_in.now - last_seen;
  assign old      = valid && (age > {16'd0, max_age});

  always_comb begin
    tok_next = tok_in;
    if (is_frame) begin
      tok_next.hit = tok_in.hit | src_m;
      if (!valid) begin
        tok_next.free_found = 1'b1;
      end
      if (dst_m) begin
        tok_next.dst_found = 1'b1;
        // a refreshed source entry already carries the new port
        tok_next.dst_port  = src_m ? tok_in.ingress_port : port;
      end
    end
    if (is_tick && old && (tok_in.aged != AGED_MAX)) begin
      tok_next.aged = tok_in.aged + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      claim       <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.vld) begin
        // first free cell of this pass takes the new entry if it is learned
        claim <= is_frame && !valid && !tok_in.free_found;
      end
      if (is_tick && old) begin
        valid <= 1'b0;
      end
      if (inst.en && claim) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_frame && src_m) begin
      port      <= tok_in.ingress_port;
      last_seen <= tok_in.now;
    end
    if (inst.en && claim) begin
      mac       <= inst.mac;
      port      <= inst.port;
      last_seen <= inst.now;
    end
  end

endmodule

// File: rtl/mlbt_resolve.sv
// mlbt_resolve: turns the token leaving the chain into a result and an install
// depends on mlbt_pkg
`timescale 1ns / 1ps

module mlbt_resolve
  import mlbt_pkg::*;
#(
  parameter int NUM_PORTS = 8
) (
  input  mlbt_tok_t  tok,
  input  logic [3:0] port_count,
  output mlbt_res_t  res,
  output mlbt_inst_t inst
);

  logic       learned;
  logic       dropped;
  logic       found;
  logic [2:0] fwd_port;
  logic [3:0] n_active;
  logic [7:0] flood_mask;
  logic [7:0] fwd_mask;

  assign learned  = !tok.hit && tok.free_found;
  assign dropped  = !tok.hit && !tok.free_found;
  // destination equal to a just-learned source is found at the ingress port
  assign found    = tok.dst_found || ((tok.dst_mac == tok.src_mac) && !dropped);
  assign fwd_port = tok.dst_found ? tok.dst_port : tok.ingress_port;
  assign n_active = (port_count > 4'(NUM_PORTS)) ? 4'(NUM_PORTS) : port_count;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      flood_mask[b] = (4'(b) < n_active) && (3'(b) != tok.ingress_port);
      fwd_mask[b]   = (3'(b) == fwd_port) && (b < NUM_PORTS);
    end
  end

  always_comb begin
    res = '0;
    if (tok.kind == KIND_TICK) begin
      res.action     = ACT_TICK;
      res.aged_count = tok.aged;
    end else begin
      res.learned_new   = learned;
      res.learn_dropped = dropped;
      if (!found) begin
        res.action    = ACT_FLOOD;
        res.port_mask = flood_mask;
      end else if (fwd_port != tok.ingress_port) begin
        res.action    = ACT_FORWARD;
        res.port_mask = fwd_mask;
      end else begin
        res.action    = ACT_FILTER;
      end
    end
  end

  assign inst.en   = tok.vld && (tok.kind == KIND_FRAME) && learned;
  assign inst.mac  = tok.src_mac;
  assign inst.port = tok.ingress_port;
  assign inst.now  = tok.now;

endmodule
